// ===== rtl/core/cesd_pkg.sv =====
// Package for the C escape sequence decoder: channel word types, parser modes,
// status codes and character constants. No dependencies.
package cesd_pkg;

	// Input word: one raw character of the string
	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_word_t;

	// Output word: one decoded result
	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_valid;
		logic [2:0] status;
		logic       out_last;
	} out_word_t;

	// Up to two results produced by one character
	typedef struct packed {
		logic [1:0] count;
		out_word_t  first;
		out_word_t  second;
	} pair_t;

	// Parser modes
	typedef enum logic [2:0] {
		MODE_TEXT = 3'd0,
		MODE_BSL  = 3'd1,
		MODE_HEX  = 3'd2,
		MODE_UNI  = 3'd3,
		MODE_OCT1 = 3'd4,
		MODE_OCT2 = 3'd5
	} mode_t;

	// Status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_UNKNOWN   = 3'd1;
	localparam logic [2:0] ST_HEX_EMPTY = 3'd2;
	localparam logic [2:0] ST_HEX_RANGE = 3'd3;
	localparam logic [2:0] ST_OCT_RANGE = 3'd4;
	localparam logic [2:0] ST_UNICODE   = 3'd5;
	localparam logic [2:0] ST_TRUNC     = 3'd6;

	// Characters
	localparam logic [7:0] CH_BSL    = 8'h5C;
	localparam logic [7:0] CH_QUOTE  = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_QMARK  = 8'h3F;
	localparam logic [7:0] CH_X      = 8'h78;
	localparam logic [7:0] CH_LU     = 8'h75;
	localparam logic [7:0] CH_UU     = 8'h55;
	localparam logic [7:0] CH_A      = 8'h61;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_V      = 8'h76;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_SEVEN  = 8'h37;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_UA     = 8'h41;
	localparam logic [7:0] CH_UF     = 8'h46;

endpackage

// ===== rtl/core/cesd_decode.sv =====
// Escape parser: mode and accumulator registers plus the combinational decode
// of one character into up to two results. Depends on cesd_pkg.
module cesd_decode import cesd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     take,
	input  in_word_t word,
	output pair_t    pair
);

	mode_t      mode_q, mode_d;
	logic [8:0] value_q, value_d;
	logic       ovf_q, ovf_d;
	logic       seen_q, seen_d;

	// Hex digit: valid flag and nibble
	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [7:0] t;
		begin
			t = 8'd0;
			if (c >= CH_ZERO && c <= CH_NINE) begin
				t = c - CH_ZERO;
				hex_val = {1'b1, t[3:0]};
			end else if (c >= CH_A && c <= CH_F) begin
				t = c - CH_A + 8'd10;
				hex_val = {1'b1, t[3:0]};
			end else if (c >= CH_UA && c <= CH_UF) begin
				t = c - CH_UA + 8'd10;
				hex_val = {1'b1, t[3:0]};
			end else begin
				hex_val = 5'd0;
			end
		end
	endfunction

	// Build a result; a result with no byte carries zero
	function automatic out_word_t mk(input logic [7:0] data, input logic vld,
			input logic [2:0] st);
		out_word_t w;
		begin
			w.out_byte  = vld ? data : 8'd0;
			w.out_valid = vld;
			w.status    = st;
			w.out_last  = 1'b0;
			mk = w;
		end
	endfunction

	function automatic out_word_t fin_hex(input logic [8:0] v, input logic ovf,
			input logic seen);
		begin
			if (!seen) fin_hex = mk(8'd0, 1'b0, ST_HEX_EMPTY);
			else fin_hex = mk(v[7:0], 1'b1, ovf ? ST_HEX_RANGE : ST_OK);
		end
	endfunction

	function automatic out_word_t fin_oct(input logic [8:0] v);
		begin
			fin_oct = mk(v[7:0], 1'b1, v[8] ? ST_OCT_RANGE : ST_OK);
		end
	endfunction

	// Hold parser state until a character is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_TEXT;
			value_q <= 9'd0;
			ovf_q   <= 1'b0;
			seen_q  <= 1'b0;
		end else if (take) begin
			mode_q  <= mode_d;
			value_q <= value_d;
			ovf_q   <= ovf_d;
			seen_q  <= seen_d;
		end
	end

	logic [7:0] ch;
	logic       is_oct;
	logic [4:0] hx;
	logic [8:0] oct_next;

	assign ch       = word.in_byte;
	assign is_oct   = (ch >= CH_ZERO) && (ch <= CH_SEVEN);
	assign hx       = hex_val(ch);
	assign oct_next = {value_q[5:0], ch[2:0]};

	// Decode one character: escape close, text byte, end-of-string close
	always_comb begin
		mode_t      mode_m;
		logic [8:0] val_m;
		logic       ovf_m, seen_m;
		logic       a_en, b_en, c_en, d_en, text_go;
		out_word_t  a_w, b_w, c_w, d_w;
		logic [1:0] n;
		out_word_t  r0, r1;

		mode_m  = mode_q;
		val_m   = value_q;
		ovf_m   = ovf_q;
		seen_m  = seen_q;
		a_en    = 1'b0;
		a_w     = mk(8'd0, 1'b0, ST_OK);
		text_go = 1'b0;
		c_en    = 1'b0;
		c_w     = mk(8'd0, 1'b0, ST_OK);

		unique case (mode_q)
			MODE_BSL: begin
				val_m  = 9'd0;
				ovf_m  = 1'b0;
				seen_m = 1'b0;
				if (ch == CH_X) begin
					mode_m = MODE_HEX;
				end else if (ch == CH_LU || ch == CH_UU) begin
					mode_m = MODE_UNI;
				end else if (is_oct) begin
					mode_m = MODE_OCT1;
					val_m  = {6'd0, ch[2:0]};
				end else begin
					mode_m = MODE_TEXT;
					a_en   = 1'b1;
					case (ch)
						CH_QUOTE, CH_DQUOTE, CH_QMARK, CH_BSL: a_w = mk(ch, 1'b1, ST_OK);
						CH_A: a_w = mk(8'd7, 1'b1, ST_OK);
						CH_B: a_w = mk(8'd8, 1'b1, ST_OK);
						CH_F: a_w = mk(8'd12, 1'b1, ST_OK);
						CH_N: a_w = mk(8'd10, 1'b1, ST_OK);
						CH_R: a_w = mk(8'd13, 1'b1, ST_OK);
						CH_T: a_w = mk(8'd9, 1'b1, ST_OK);
						CH_V: a_w = mk(8'd11, 1'b1, ST_OK);
						default: a_w = mk(ch, 1'b1, ST_UNKNOWN);
					endcase
				end
			end
			MODE_HEX: begin
				if (hx[4]) begin
					ovf_m  = ovf_q | (value_q[7:4] != 4'd0);
					val_m  = {1'b0, value_q[3:0], hx[3:0]};
					seen_m = 1'b1;
				end else begin
					a_en    = 1'b1;
					a_w     = fin_hex(value_q, ovf_q, seen_q);
					text_go = 1'b1;
				end
			end
			MODE_UNI: begin
				if (!hx[4]) begin
					a_en    = 1'b1;
					a_w     = mk(8'd0, 1'b0, ST_UNICODE);
					text_go = 1'b1;
				end
			end
			MODE_OCT1: begin
				if (is_oct) begin
					mode_m = MODE_OCT2;
					val_m  = oct_next;
				end else begin
					a_en    = 1'b1;
					a_w     = fin_oct(value_q);
					text_go = 1'b1;
				end
			end
			MODE_OCT2: begin
				a_en = 1'b1;
				if (is_oct) begin
					a_w    = fin_oct(oct_next);
					mode_m = MODE_TEXT;
					val_m  = 9'd0;
					ovf_m  = 1'b0;
					seen_m = 1'b0;
				end else begin
					a_w     = fin_oct(value_q);
					text_go = 1'b1;
				end
			end
			default: begin
				text_go = 1'b1;
			end
		endcase

		// Close the escape and handle the character as text
		if (text_go) begin
			if (mode_q != MODE_TEXT && mode_q != MODE_BSL) begin
				val_m  = 9'd0;
				ovf_m  = 1'b0;
				seen_m = 1'b0;
			end
			mode_m = (ch == CH_BSL) ? MODE_BSL : MODE_TEXT;
		end
		b_en = text_go && (ch != CH_BSL);
		b_w  = mk(ch, 1'b1, ST_OK);

		// Finish whatever escape is still open at end of string
		if (word.in_last) begin
			unique case (mode_m)
				MODE_BSL: begin
					c_en = 1'b1;
					c_w  = mk(8'd0, 1'b0, ST_TRUNC);
				end
				MODE_HEX: begin
					c_en = 1'b1;
					c_w  = fin_hex(val_m, ovf_m, seen_m);
				end
				MODE_UNI: begin
					c_en = 1'b1;
					c_w  = mk(8'd0, 1'b0, ST_UNICODE);
				end
				MODE_OCT1, MODE_OCT2: begin
					c_en = 1'b1;
					c_w  = fin_oct(val_m);
				end
				default: c_en = 1'b0;
			endcase
		end
		d_en = word.in_last && !a_en && !b_en && !c_en;
		d_w  = mk(8'd0, 1'b0, ST_OK);

		// Pack the enabled results in order
		n = {1'b0, a_en} + {1'b0, b_en} + {1'b0, c_en} + {1'b0, d_en};
		if (a_en) begin
			r0 = a_w;
			r1 = b_en ? b_w : c_w;
		end else if (b_en) begin
			r0 = b_w;
			r1 = c_w;
		end else begin
			r0 = c_en ? c_w : d_w;
			r1 = d_w;
		end
		if (word.in_last) begin
			if (n == 2'd2) r1.out_last = 1'b1;
			else r0.out_last = 1'b1;
		end

		pair.count  = n;
		pair.first  = r0;
		pair.second = r1;

		// Return to text mode at end of string
		if (word.in_last) begin
			mode_d  = MODE_TEXT;
			value_d = 9'd0;
			ovf_d   = 1'b0;
			seen_d  = 1'b0;
		end else begin
			mode_d  = mode_m;
			value_d = val_m;
			ovf_d   = ovf_m;
			seen_d  = seen_m;
		end
	end

`ifndef ASSERT_OFF
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		take && word.in_last |=> mode_q == MODE_TEXT && value_q == 9'd0 && !seen_q)
		else $error("parser state not cleared after end of string");
	a_last_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		take && word.in_last |-> pair.count != 2'd0)
		else $error("end of string produced no result");
	a_oct2_range: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_OCT2 |-> value_q[8:6] == 3'd0)
		else $error("octal accumulator too wide after two digits");
`endif

endmodule

// ===== rtl/core/cesd_out_queue.sv =====
// Two-entry result buffer that drains one decoded word per cycle toward the
// receiver when not stalled, refilled only as it empties. Depends on cesd_pkg.
module cesd_out_queue import cesd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  pair_t     pair,
	output logic      room,
	output logic      res_valid,
	input  logic      res_stall,
	output out_word_t res_word
);

	logic [1:0] count_q;
	out_word_t  head_q, tail_q;
	logic       pop;

	assign pop       = (count_q != 2'd0) && !res_stall;
	assign room      = (count_q == 2'd0) || (count_q == 2'd1 && !res_stall);
	assign res_valid = count_q != 2'd0;
	assign res_word  = head_q;

	// Track how many words are held
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else if (load) begin
			count_q <= pair.count;
		end else if (pop) begin
			count_q <= count_q - 2'd1;
		end
	end

	// Load a fresh pair or advance the tail into the head
	always_ff @(posedge clk) begin
		if (load) begin
			head_q <= pair.first;
			tail_q <= pair.second;
		end else if (pop) begin
			head_q <= tail_q;
		end
	end

`ifndef ASSERT_OFF
	a_load_room: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> room)
		else $error("pair loaded while buffer still holds words");
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("result buffer overfilled");
	a_drain_second: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == 2'd2 && pop |=> res_valid && res_word == $past(tail_q))
		else $error("second result lost");
`endif

endmodule

// ===== rtl/core/c_escape_sequence_decoder.sv =====
// Top level of the C escape sequence decoder: input register, parser and
// result buffer. Depends on cesd_pkg, cesd_decode and cesd_out_queue.
//
// Usage:
//   The char channel (char_valid, char_stall, char_word) takes one raw string
//   character per word, with in_last set on the final character. The res
//   channel (res_valid, res_stall, res_word) gives decoded words; a word is
//   moved at a clock edge where valid is high and stall is low.
//   A character gives zero, one or two result words; the end of a string
//   always gives at least one, with out_last set on its final word.
//   Path: an accepted character waits in the input register, is decoded
//   combinationally when the parser takes it, and leaves via the buffer.
//   Throughput: one character per cycle while each gives at most one word and
//   the receiver takes every word; a character giving two words stalls the
//   next one, since the buffer drains one word per cycle while not stalled.
//   When the receiver stalls, words hold in the two-entry buffer and the
//   input register; char_stall rises while the input register holds a word
//   and the buffer still has a word that cannot leave in that cycle.
//   Reset clears the parser to text mode and empties the buffers; the block
//   accepts characters as soon as reset is released.
module c_escape_sequence_decoder import cesd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      char_valid,
	output logic      char_stall,
	input  in_word_t  char_word,
	output logic      res_valid,
	input  logic      res_stall,
	output out_word_t res_word
);

	in_word_t word_s1;
	logic     vld_s1;
	logic     room;
	logic     advance;
	pair_t    pair;

	assign advance    = vld_s1 && room;
	assign char_stall = vld_s1 && !room;

	// Hold the input word until the parser takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!char_stall) begin
			vld_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!char_stall && char_valid) begin
			word_s1 <= char_word;
		end
	end

	cesd_decode u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (advance),
		.word   (word_s1),
		.pair   (pair)
	);

	cesd_out_queue u_out_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance),
		.pair      (pair),
		.room      (room),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_word  (res_word)
	);

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Testbench for c_escape_sequence_decoder: directed and random strings, checked
// word by word against an in-bench decoder. Depends on cesd_pkg and the RTL.
module tb import cesd_pkg::*;;

	localparam int CLK_HALF    = 6;
	localparam int RESET_CYCLES = 12;
	localparam int RANDOM_CHARS = 1700;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int MAX_REPORTS  = 10;

	logic      clk        = 1'b0;
	logic      arst_n     = 1'b0;
	logic      char_valid = 1'b0;
	logic      char_stall;
	in_word_t  char_word  = '0;
	logic      res_valid;
	logic      res_stall  = 1'b0;
	out_word_t res_word;

	// Idle rates of sender and receiver, in percent
	int gap_pct   = 16;
	int stall_pct = 16;

	int cycles     = 0;
	int mismatches = 0;
	int chars_sent = 0;
	int words_seen = 0;
	int strings_sent = 0;

	// Decoder state mirrored in the bench
	mode_t      dec_mode  = MODE_TEXT;
	logic [8:0] dec_value = '0;
	logic       dec_ovf   = 1'b0;
	logic       dec_seen  = 1'b0;

	out_word_t step_words[$];
	out_word_t pending_words[$];

	logic [7:0] simple_chars [11] = '{CH_QUOTE, CH_DQUOTE, CH_QMARK, CH_BSL, CH_A, CH_B,
		CH_F, CH_N, CH_R, CH_T, CH_V};

	c_escape_sequence_decoder i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_word  (char_word),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res_word   (res_word)
	);

	// Clock
	always #CLK_HALF clk = ~clk;

	// Run guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words outstanding", cycles,
				pending_words.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Receiver back-pressure
	always @(posedge clk) begin
		res_stall <= arst_n && ($urandom_range(99) < stall_pct);
	end

	// ---------------------------------------------------------------
	// Decoder prediction
	// ---------------------------------------------------------------

	function automatic void clear_escape_state();
		dec_mode  = MODE_TEXT;
		dec_value = '0;
		dec_ovf   = 1'b0;
		dec_seen  = 1'b0;
	endfunction

	function automatic void emit_word(logic [7:0] b, logic v, logic [2:0] st);
		out_word_t w;
		if (step_words.size() >= 2)
			return;
		w.out_byte  = v ? b : 8'h00;
		w.out_valid = v;
		w.status    = st;
		w.out_last  = 1'b0;
		step_words.push_back(w);
	endfunction

	function automatic int hex_value(logic [7:0] c);
		if (c >= CH_ZERO && c <= CH_NINE)
			return int'(c - CH_ZERO);
		if (c >= CH_A && c <= CH_F)
			return int'(c - CH_A) + 10;
		if (c >= CH_UA && c <= CH_UF)
			return int'(c - CH_UA) + 10;
		return -1;
	endfunction

	function automatic void close_hex();
		if (!dec_seen)
			emit_word(8'h00, 1'b0, ST_HEX_EMPTY);
		else
			emit_word(dec_value[7:0], 1'b1, dec_ovf ? ST_HEX_RANGE : ST_OK);
		clear_escape_state();
	endfunction

	function automatic void close_octal();
		emit_word(dec_value[7:0], 1'b1, (dec_value >= 9'd256) ? ST_OCT_RANGE : ST_OK);
		clear_escape_state();
	endfunction

	function automatic void plain_text(logic [7:0] b);
		if (b == CH_BSL)
			dec_mode = MODE_BSL;
		else
			emit_word(b, 1'b1, ST_OK);
	endfunction

	function automatic void simple_escape(logic [7:0] b);
		logic [7:0] v;
		logic [2:0] st;
		v  = b;
		st = ST_OK;
		case (b)
			CH_QUOTE, CH_DQUOTE, CH_QMARK, CH_BSL: v = b;
			CH_A: v = 8'd7;
			CH_B: v = 8'd8;
			CH_F: v = 8'd12;
			CH_N: v = 8'd10;
			CH_R: v = 8'd13;
			CH_T: v = 8'd9;
			CH_V: v = 8'd11;
			default: st = ST_UNKNOWN;
		endcase
		emit_word(v, 1'b1, st);
		clear_escape_state();
	endfunction

	// Work out the result words of one accepted character word
	function automatic void decode_char(in_word_t w);
		logic [7:0] b;
		int         d;
		logic       oct;
		out_word_t  tail;
		b   = w.in_byte;
		d   = hex_value(b);
		oct = (b >= CH_ZERO && b <= CH_SEVEN);
		step_words.delete();

		case (dec_mode)
			MODE_BSL: begin
				if (b == CH_X) begin
					clear_escape_state();
					dec_mode = MODE_HEX;
				end else if (b == CH_LU || b == CH_UU) begin
					clear_escape_state();
					dec_mode = MODE_UNI;
				end else if (oct) begin
					clear_escape_state();
					dec_value = 9'(b - CH_ZERO);
					dec_mode  = MODE_OCT1;
				end else begin
					simple_escape(b);
				end
			end
			MODE_HEX: begin
				if (d >= 0) begin
					if (dec_value[7:0] >= 8'd16)
						dec_ovf = 1'b1;
					dec_value = {1'b0, dec_value[3:0], 4'(d)};
					dec_seen  = 1'b1;
				end else begin
					close_hex();
					plain_text(b);
				end
			end
			MODE_UNI: begin
				if (d < 0) begin
					emit_word(8'h00, 1'b0, ST_UNICODE);
					clear_escape_state();
					plain_text(b);
				end
			end
			MODE_OCT1: begin
				if (oct) begin
					dec_value = {dec_value[5:0], 3'(b - CH_ZERO)};
					dec_mode  = MODE_OCT2;
				end else begin
					close_octal();
					plain_text(b);
				end
			end
			MODE_OCT2: begin
				if (oct)
					dec_value = {dec_value[5:0], 3'(b - CH_ZERO)};
				close_octal();
				if (!oct)
					plain_text(b);
			end
			default: begin
				dec_mode = MODE_TEXT;
				plain_text(b);
			end
		endcase

		// Close any open escape at end of string
		if (w.in_last) begin
			case (dec_mode)
				MODE_BSL:             emit_word(8'h00, 1'b0, ST_TRUNC);
				MODE_HEX:             close_hex();
				MODE_UNI:             emit_word(8'h00, 1'b0, ST_UNICODE);
				MODE_OCT1, MODE_OCT2: close_octal();
				default: ;
			endcase
			clear_escape_state();
			if (step_words.size() == 0)
				emit_word(8'h00, 1'b0, ST_OK);
			tail = step_words[step_words.size() - 1];
			tail.out_last = 1'b1;
			step_words[step_words.size() - 1] = tail;
		end

		foreach (step_words[i])
			pending_words.push_back(step_words[i]);
	endfunction

	// ---------------------------------------------------------------
	// Result checking
	// ---------------------------------------------------------------

	always @(posedge clk) begin
		out_word_t want;
		if (arst_n && res_valid && !res_stall) begin
			words_seen++;
			if (pending_words.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: unexpected word byte=%02h valid=%b status=%0d last=%b",
						$realtime, res_word.out_byte, res_word.out_valid,
						res_word.status, res_word.out_last);
			end else begin
				want = pending_words.pop_front();
				if (res_word.out_byte !== want.out_byte ||
						res_word.out_valid !== want.out_valid ||
						res_word.status !== want.status ||
						res_word.out_last !== want.out_last) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: expected %02h/%b/%0d/%b, got %02h/%b/%0d/%b",
							$realtime, want.out_byte, want.out_valid, want.status,
							want.out_last, res_word.out_byte, res_word.out_valid,
							res_word.status, res_word.out_last);
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------

	// Offer one character word and hold it until taken
	task automatic send_char(input logic [7:0] b, input logic l);
		in_word_t w;
		w.in_byte = b;
		w.in_last = l;
		while ($urandom_range(99) < gap_pct) begin
			char_valid <= 1'b0;
			@(posedge clk);
		end
		char_valid <= 1'b1;
		char_word  <= w;
		do
			@(posedge clk);
		while (char_stall);
		decode_char(w);
		chars_sent++;
		if (l)
			strings_sent++;
	endtask

	task automatic send_str(input string s, input bit close);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], close && (i == s.len() - 1));
	endtask

	// Hold the sender until every predicted word has come back
	task automatic wait_drained();
		char_valid <= 1'b0;
		@(posedge clk);
		while (pending_words.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] rand_hex_char();
		int v;
		v = $urandom_range(21);
		if (v < 10)
			return CH_ZERO + 8'(v);
		if (v < 16)
			return CH_A + 8'(v - 10);
		return CH_UA + 8'(v - 16);
	endfunction

	function automatic logic [7:0] rand_plain_char();
		logic [7:0] c;
		c = 8'($urandom_range(255));
		if (c == CH_BSL)
			c = CH_QMARK;
		return c;
	endfunction

	// Append one random piece of string literal text
	function automatic void add_piece(ref logic [7:0] q[$]);
		int kind;
		int n;
		kind = $urandom_range(6);
		if (kind != 0)
			q.push_back(CH_BSL);
		case (kind)
			0: begin
				n = $urandom_range(3, 1);
				repeat (n) q.push_back(rand_plain_char());
			end
			1: q.push_back(simple_chars[$urandom_range(10)]);
			2: begin
				q.push_back(CH_X);
				n = ($urandom_range(7) == 0) ? $urandom_range(6, 3) : $urandom_range(3);
				repeat (n) q.push_back(rand_hex_char());
			end
			3: begin
				n = $urandom_range(3, 1);
				repeat (n) q.push_back(CH_ZERO + 8'($urandom_range(7)));
			end
			4: begin
				q.push_back($urandom_range(1) ? CH_LU : CH_UU);
				n = $urandom_range(8);
				repeat (n) q.push_back(rand_hex_char());
			end
			5: q.push_back(8'($urandom_range(255)));
			default: ;
		endcase
	endfunction

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	task automatic test_plain_extremes();
		send_char(8'h00, 1'b0);
		send_char(8'hFF, 1'b1);
	endtask

	task automatic test_simple_escapes();
		send_str("\\a\\b\\f\\n\\r\\t\\v\\'\\\"\\?\\\\", 1'b1);
	endtask

	// Range overflow, no digits mid-string and at end of string
	task automatic test_hex_escapes();
		send_str("\\x1ff\\xz\\x", 1'b1);
	endtask

	// Out of range, one digit then text, two digits at end of string
	task automatic test_octal_escapes();
		send_str("\\777\\7z\\12", 1'b1);
	endtask

	// Unicode, unknown escape and a trailing backslash
	task automatic test_unicode_unknown_truncated();
		send_str("\\u00e9a\\q\\", 1'b1);
	endtask

	// Stop in the middle of a hex escape until all words are back
	task automatic test_drain_pause();
		send_str("\\x4", 1'b0);
		wait_drained();
		send_str("1", 1'b1);
	endtask

	task automatic test_random_strings();
		logic [7:0] text[$];
		int         start;
		int         pieces;
		int         next_pause;
		start      = chars_sent;
		next_pause = start + 200;
		while (chars_sent - start < RANDOM_CHARS) begin
			// run a stretch with no idling on either side
			if (chars_sent - start >= 600 && chars_sent - start < 900) begin
				gap_pct   = 0;
				stall_pct = 0;
			end else begin
				gap_pct   = 16;
				stall_pct = 16;
			end
			if (chars_sent >= next_pause) begin
				wait_drained();
				next_pause = chars_sent + 200;
			end
			if ($urandom_range(99) < 20) begin
				send_char(8'($urandom_range(255)), $urandom_range(7) == 0);
			end else begin
				text.delete();
				pieces = $urandom_range(5, 1);
				repeat (pieces) add_piece(text);
				foreach (text[i])
					send_char(text[i], i == text.size() - 1);
			end
		end
		gap_pct   = 16;
		stall_pct = 16;
	endtask

	// ---------------------------------------------------------------
	// Sequence
	// ---------------------------------------------------------------

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_plain_extremes();
		test_simple_escapes();
		test_hex_escapes();
		test_octal_escapes();
		test_unicode_unknown_truncated();
		test_drain_pause();
		test_random_strings();

		// Drain and let the pipeline settle
		char_valid <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("decoded %0d characters in %0d strings, %0d result words checked",
			chars_sent, strings_sent, words_seen);
		$display("%0d mismatches, %0d words left unmatched", mismatches,
			pending_words.size());
		if (mismatches == 0 && pending_words.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/cesd_pkg.sv
rtl/core/cesd_decode.sv
rtl/core/cesd_out_queue.sv
rtl/core/c_escape_sequence_decoder.sv
tb/sv/tb.sv
